/* hdl/header_q_word_encoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// Header Q-word encoder assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HEADER_Q_WORD_ENCODER_UNIT_MACROS_SVH
`define HEADER_Q_WORD_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define HQWE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hqwe assertion failed");
// Check that an antecedent implies a consequent in the same cycle
`define HQWE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hqwe implication failed");
// Check that an antecedent implies a consequent in the next cycle
`define HQWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hqwe next-cycle check failed");
`else
`define HQWE_ASSERT(lbl, clk, rst_n, prop)
`define HQWE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HQWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/hqwe_pkg.sv */
// ----------------------------------------------------------------------------
// Header Q-word encoder package
// Shared types, character constants and helpers.
// ----------------------------------------------------------------------------
package hqwe_pkg;

  // Largest supported charset name, in bytes
  localparam int CHARSET_MAX_BYTES = 8;
  localparam int CFG_DATA_W        = 64;
  localparam int CHARSET_LEN_W     = 4;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CHARSET_BYTES = 1'b0,
    CFG_CHARSET_LEN   = 1'b1
  } cfg_reg_e;

  // Characters used in the encoded word
  localparam logic [7:0] CHAR_EQ    = 8'h3d;  // '='
  localparam logic [7:0] CHAR_QMARK = 8'h3f;  // '?'
  localparam logic [7:0] CHAR_UNDER = 8'h5f;  // '_'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHAR_Q     = 8'h51;  // 'Q'
  localparam logic [7:0] CTRL_MAX   = 8'h1f;
  localparam logic [7:0] CHAR_DEL   = 8'h7f;

  // Input beat payload
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  // Output beat payload
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_beat_t;

  // Description of the character run caused by one input byte
  typedef struct packed {
    logic       open_word;   // emit "=?" charset "?Q?" first
    logic       escape;      // emit "=HH" instead of the raw byte
    logic       close_word;  // append "?=" at the end
    logic [7:0] text_byte;
  } run_desc_t;

  // Upper-case hex digit table
  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] hex_digit(logic [3:0] nibble);
    return HEX_DIGITS[nibble];
  endfunction

endpackage

/* hdl/hqwe_stream_if.sv */
// ----------------------------------------------------------------------------
// Header Q-word encoder stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hqwe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/hqwe_scan.sv */
// ----------------------------------------------------------------------------
// Header Q-word encoder scanner
// Classifies each accepted byte and tracks the per-string mode bits.
// ----------------------------------------------------------------------------
module hqwe_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hqwe_pkg::in_beat_t  beat_i,
  output hqwe_pkg::run_desc_t desc_o
);

  logic       encoding_q, encoding_d;
  logic       blanks_q, blanks_d;
  logic [7:0] c;
  logic       last;
  logic       special;
  logic       plain;
  logic       is_space;
  logic       start;
  logic       active_after;

  assign c        = beat_i.text_byte;
  assign last     = beat_i.end_of_text;
  assign is_space = (c == hqwe_pkg::CHAR_SPACE);

  // Classify the byte
  assign special = (c == hqwe_pkg::CHAR_EQ) || (c == hqwe_pkg::CHAR_QMARK) ||
                   (c == hqwe_pkg::CHAR_UNDER) || (c <= hqwe_pkg::CTRL_MAX) ||
                   (c >= hqwe_pkg::CHAR_DEL);
  assign plain   = !special;

  // Open a word on a special byte, or on a final space after only blanks
  assign start        = !encoding_q && (!plain || (blanks_q && is_space && last));
  assign active_after = encoding_q || start;

  // Build the run description
  always_comb begin
    desc_o.open_word  = start;
    desc_o.escape     = active_after && (special || is_space);
    desc_o.close_word = active_after && last;
    desc_o.text_byte  = c;
  end

  // Next mode bits; reset both after a final byte
  always_comb begin
    encoding_d = active_after;
    blanks_d   = blanks_q;
    if (!encoding_q && plain && blanks_q && !is_space) begin
      blanks_d = 1'b0;
    end
    if (last) begin
      encoding_d = 1'b0;
      blanks_d   = 1'b1;
    end
  end

  // Hold mode bits between accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q <= 1'b0;
      blanks_q   <= 1'b1;
    end else if (accept_i) begin
      encoding_q <= encoding_d;
      blanks_q   <= blanks_d;
    end
  end

endmodule

/* hdl/hqwe_serializer.sv */
// ----------------------------------------------------------------------------
// Header Q-word encoder serializer
// Holds one run description and emits its characters, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "header_q_word_encoder_unit_macros.svh"

module hqwe_serializer #(
  parameter int CharsetMaxBytes = hqwe_pkg::CHARSET_MAX_BYTES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  hqwe_pkg::run_desc_t                  desc_i,
  input  logic [hqwe_pkg::CFG_DATA_W-1:0]      charset_bytes_i,
  input  logic [hqwe_pkg::CHARSET_LEN_W-1:0]   charset_len_i,
  output logic                                 slot_ready_o,
  output logic                                 out_valid_o,
  output hqwe_pkg::out_beat_t                  out_beat_o,
  input  logic                                 out_ready_i
);

  localparam int PosW = $clog2(CharsetMaxBytes + 11);
  localparam int IdxW = (CharsetMaxBytes > 1) ? $clog2(CharsetMaxBytes) : 1;

  logic                item_valid_q;
  hqwe_pkg::run_desc_t item_q;
  logic [PosW-1:0]     pos_q;
  logic                out_valid_q;
  hqwe_pkg::out_beat_t out_beat_q;

  logic [PosW-1:0] len_ext;
  logic [PosW-1:0] hdr_len;
  logic [PosW-1:0] body_len;
  logic [PosW-1:0] total_len;
  logic [PosW-1:0] last_pos;
  logic [PosW-1:0] cs_end;
  logic [PosW-1:0] cs_off;
  logic [PosW-1:0] tag_off;
  logic [PosW-1:0] body_off;
  logic [PosW-1:0] close_off;
  logic [IdxW-1:0] cs_idx;
  logic [7:0]      cur_char;
  logic            at_last;
  logic            advance;
  logic            finish;

  // Run layout: header, body, closing
  assign len_ext   = PosW'(charset_len_i);
  assign hdr_len   = item_q.open_word ? (len_ext + PosW'(5)) : '0;
  assign body_len  = item_q.escape ? PosW'(3) : PosW'(1);
  assign total_len = hdr_len + body_len + (item_q.close_word ? PosW'(2) : '0);
  assign last_pos  = total_len - PosW'(1);
  assign at_last   = (pos_q == last_pos);

  // Offsets into each segment
  assign cs_end    = PosW'(2) + len_ext;
  assign cs_off    = pos_q - PosW'(2);
  assign tag_off   = pos_q - cs_end;
  assign body_off  = pos_q - hdr_len;
  assign close_off = body_off - body_len;
  assign cs_idx    = cs_off[IdxW-1:0];

  // Pick the character at the current position
  always_comb begin
    cur_char = item_q.text_byte;
    if (pos_q < hdr_len) begin
      if (pos_q == '0) begin
        cur_char = hqwe_pkg::CHAR_EQ;
      end else if (pos_q == PosW'(1)) begin
        cur_char = hqwe_pkg::CHAR_QMARK;
      end else if (pos_q < cs_end) begin
        cur_char = charset_bytes_i[{cs_idx, 3'b000} +: 8];
      end else if (tag_off == PosW'(1)) begin
        cur_char = hqwe_pkg::CHAR_Q;
      end else begin
        cur_char = hqwe_pkg::CHAR_QMARK;
      end
    end else if (body_off < body_len) begin
      if (!item_q.escape) begin
        cur_char = item_q.text_byte;
      end else if (body_off == '0) begin
        cur_char = hqwe_pkg::CHAR_EQ;
      end else if (body_off == PosW'(1)) begin
        cur_char = hqwe_pkg::hex_digit(item_q.text_byte[7:4]);
      end else begin
        cur_char = hqwe_pkg::hex_digit(item_q.text_byte[3:0]);
      end
    end else if (close_off == '0) begin
      cur_char = hqwe_pkg::CHAR_QMARK;
    end else begin
      cur_char = hqwe_pkg::CHAR_EQ;
    end
  end

  // Advance when the output register is free or drains this cycle
  assign advance      = item_valid_q && (!out_valid_q || out_ready_i);
  assign finish       = advance && at_last;
  assign slot_ready_o = !item_valid_q || finish;

  // Hold the current run and its position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      pos_q        <= '0;
    end else if (accept_i) begin
      item_valid_q <= 1'b1;
      pos_q        <= '0;
    end else if (finish) begin
      item_valid_q <= 1'b0;
    end else if (advance) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  // Load the run payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= desc_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_beat_q.out_char    <= cur_char;
      out_beat_q.last_of_run <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Position never runs past the end of the run
  `HQWE_ASSERT_IMPL(a_pos_in_run, clk_i, rst_ni, item_valid_q, pos_q <= last_pos)
  // A new run is taken only into a free or finishing slot
  `HQWE_ASSERT_IMPL(a_accept_slot, clk_i, rst_ni, accept_i, !item_valid_q || finish)
  // The final character of a run carries the run end mark
  `HQWE_ASSERT_NEXT(a_last_mark, clk_i, rst_ni, finish, out_valid_q && out_beat_q.last_of_run)

endmodule

/* hdl/header_q_word_encoder_unit.sv */
// The first character of a run passes through the run register and then the output register.
// Throughput: one output character per cycle while the receiver is ready; a byte holds the
// serializer until all its characters (1, 3, 5 or up to charset length + 10) are emitted.
// A byte is accepted in the cycle its predecessor's last character enters the output.
// Reset (async, active low) clears the mode bits, the pipeline and the charset registers.
// ----------------------------------------------------------------------------
// Header Q-word encoder top level
// Encodes header strings into Q-encoded words with a configured charset.
// ----------------------------------------------------------------------------
module header_q_word_encoder_unit #(
  parameter int CharsetMaxBytes = hqwe_pkg::CHARSET_MAX_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [hqwe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  hqwe_stream_if.sink                     in_if,
  hqwe_stream_if.source                   out_if
);

  localparam int LenW = hqwe_pkg::CHARSET_LEN_W;

  logic [hqwe_pkg::CFG_DATA_W-1:0] charset_bytes_q;
  logic [LenW-1:0]                 charset_len_q;
  logic [LenW-1:0]                 charset_len_clamped;
  logic                            slot_ready;
  logic                            in_accept;
  hqwe_pkg::in_beat_t              in_beat;
  hqwe_pkg::run_desc_t             desc;
  hqwe_pkg::out_beat_t             out_beat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_bytes_q <= '0;
      charset_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hqwe_pkg::CFG_CHARSET_BYTES: charset_bytes_q <= cfg_wdata_i;
        hqwe_pkg::CFG_CHARSET_LEN:   charset_len_q   <= cfg_wdata_i[LenW-1:0];
      endcase
    end
  end

  // Limit the charset length to the supported maximum
  assign charset_len_clamped = (charset_len_q > LenW'(CharsetMaxBytes)) ?
                               LenW'(CharsetMaxBytes) : charset_len_q;

  // Input handshake
  assign in_beat     = in_if.data;
  assign in_if.ready = slot_ready;
  assign in_accept   = in_if.valid && slot_ready;

  hqwe_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .beat_i   (in_beat),
    .desc_o   (desc)
  );

  hqwe_serializer #(
    .CharsetMaxBytes (CharsetMaxBytes)
  ) u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .desc_i          (desc),
    .charset_bytes_i (charset_bytes_q),
    .charset_len_i   (charset_len_clamped),
    .slot_ready_o    (slot_ready),
    .out_valid_o     (out_if.valid),
    .out_beat_o      (out_beat),
    .out_ready_i     (out_if.ready)
  );

  assign out_if.data = out_beat;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header Q-word encoder testbench
// Feeds header strings, byte by byte, through a bursty valid/ready sender and
// collects the encoded characters with a stalling receiver. A behavioral
// encoder inside the bench predicts every character, and each received beat
// is checked against the oldest prediction. The charset registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import hqwe_pkg::*;

  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [63:0] cfg_wdata;

  hqwe_stream_if #(.payload_t(in_beat_t))  text_ch ();
  hqwe_stream_if #(.payload_t(out_beat_t)) enc_ch ();

  header_q_word_encoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (text_ch),
    .out_if     (enc_ch)
  );

  // Charset shadow registers and encoder mode
  logic [63:0] name_bytes = '0;
  logic [3:0]  name_len = '0;
  logic        word_open = 1'b0;
  logic        blanks_only = 1'b1;

  // Expected characters, oldest first
  out_beat_t   expected_chars[$];
  logic [7:0]  held_char;
  logic        have_held;

  // Bytes waiting to be offered
  in_beat_t    text_queue[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;

  // Sender and receiver pacing
  int unsigned burst_left;
  int unsigned gap_left;
  logic        offering;
  logic [7:0]  stall_pattern;
  int unsigned pattern_age;
  logic        hold_off = 1'b0;
  out_beat_t   want;

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [7:0] to_hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
  endfunction

  // Queue the held character and hold the new one; the last one is marked later
  function automatic void emit(input logic [7:0] c);
    if (have_held) begin
      expected_chars.push_back(out_beat_t'({held_char, 1'b0}));
    end
    held_char = c;
    have_held = 1'b1;
  endfunction

  function automatic logic is_plain(input logic [7:0] c);
    return c != CHAR_EQ && c != CHAR_QMARK && c != CHAR_UNDER &&
           c > CTRL_MAX && c < CHAR_DEL;
  endfunction

  // Work out the characters that one text byte produces
  function automatic void encode_byte(input logic [7:0] c, input logic fin);
    logic        open_now;
    int unsigned name_cnt;
    have_held = 1'b0;
    if (!word_open) begin
      open_now = 1'b1;
      if (is_plain(c)) begin
        open_now = 1'b0;
        if (blanks_only) begin
          if (c != CHAR_SPACE) begin
            blanks_only = 1'b0;
          end else if (fin) begin
            open_now = 1'b1;
          end
        end
      end
      if (!open_now) begin
        emit(c);
      end else begin
        name_cnt = (name_len > CHARSET_MAX_BYTES) ? CHARSET_MAX_BYTES : name_len;
        emit(CHAR_EQ);
        emit(CHAR_QMARK);
        for (int unsigned k = 0; k < name_cnt; k++) begin
          emit(name_bytes[8*k +: 8]);
        end
        emit(CHAR_QMARK);
        emit(CHAR_Q);
        emit(CHAR_QMARK);
        word_open = 1'b1;
      end
    end
    if (word_open) begin
      if (c == CHAR_SPACE) begin
        emit(CHAR_EQ);
        emit("2");
        emit("0");
      end else if (!is_plain(c)) begin
        emit(CHAR_EQ);
        emit(to_hex_char(c[7:4]));
        emit(to_hex_char(c[3:0]));
      end else begin
        emit(c);
      end
      if (fin) begin
        emit(CHAR_QMARK);
        emit(CHAR_EQ);
      end
    end
    if (fin) begin
      word_open = 1'b0;
      blanks_only = 1'b1;
    end
    expected_chars.push_back(out_beat_t'({held_char, 1'b1}));
  endfunction

  // Sender: offer queued bytes in bursts, predict each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_ch.valid <= 1'b0;
      text_ch.data  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offering = text_ch.valid;
      if (text_ch.valid && text_ch.ready) begin
        encode_byte(text_ch.data.text_byte, text_ch.data.end_of_text);
        bytes_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_queue.size() > 0) begin
          text_ch.data <= text_queue.pop_front();
          offering = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      text_ch.valid <= offering;
    end
  end

  // Receiver: check each beat against the oldest expectation, stall on a pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_ch.ready <= 1'b0;
      stall_pattern = 8'hff;
      pattern_age   = 0;
    end else begin
      if (enc_ch.valid && enc_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b",
                                    enc_ch.data.out_char, enc_ch.data.last_of_run));
        end else begin
          want = expected_chars.pop_front();
          if (enc_ch.data.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char %h, want %h",
                                      enc_ch.data.out_char, want.out_char));
          end
          if (enc_ch.data.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %b, want %b on char %h",
                                      enc_ch.data.last_of_run, want.last_of_run,
                                      want.out_char));
          end
        end
      end
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        if (stall_pattern == 8'h00) begin
          stall_pattern = 8'h5a;
        end
      end else begin
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
      enc_ch.ready <= stall_pattern[0] && !hold_off;
    end
  end

  // Hold the receiver off for a long stretch so the block backs up
  initial begin
    while (bytes_accepted < 80) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == CFG_CHARSET_BYTES) begin
      name_bytes = value;
    end else begin
      name_len = value[3:0];
    end
  endtask

  // Upper bits of the length write carry noise; only the low nibble counts
  task automatic set_charset(input logic [63:0] chars, input logic [3:0] len);
    logic [63:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[3:0] = len;
    write_reg(CFG_CHARSET_BYTES, chars);
    write_reg(CFG_CHARSET_LEN, len_word);
  endtask

  task automatic push_byte(input logic [7:0] c, input logic fin);
    text_queue.push_back(in_beat_t'({c, fin}));
    bytes_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (bytes_accepted != bytes_queued || expected_chars.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random strings: mostly plain text with some specials, some left open
  task automatic queue_random_text(input int unsigned count);
    int unsigned left;
    int unsigned len;
    int unsigned lead;
    int unsigned pick;
    logic        closed;
    logic [7:0]  c;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 10);
      if (len > left) begin
        len = left;
      end
      left -= len;
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
      closed = (left == 0) || ($urandom_range(0, 9) != 0);
      for (int unsigned k = 0; k < len; k++) begin
        pick = $urandom_range(0, 19);
        if (k < lead || (pick >= 11 && pick <= 13)) begin
          c = CHAR_SPACE;
        end else if (pick <= 10) begin
          c = 8'($urandom_range(8'h21, 8'h7e));
        end else if (pick == 14) begin
          c = CHAR_EQ;
        end else if (pick == 15) begin
          c = CHAR_QMARK;
        end else if (pick == 16) begin
          c = CHAR_UNDER;
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        push_byte(c, closed && (k == len - 1));
      end
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_CHARSET_BYTES;
    cfg_wdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings under a five-character charset
    set_charset(64'h0000_0038_2d46_5455, 4'd5);
    push_byte("H", 1'b0);
    push_byte("i", 1'b1);
    // lone trailing space opens a word
    push_byte(CHAR_SPACE, 1'b1);
    // leading space then plain text stays raw
    push_byte(CHAR_SPACE, 1'b0);
    push_byte("a", 1'b1);
    push_byte(CHAR_SPACE, 1'b0);
    push_byte(CHAR_EQ, 1'b1);
    push_byte("a", 1'b0);
    push_byte(CHAR_UNDER, 1'b0);
    push_byte(CHAR_QMARK, 1'b1);
    // zero byte is a control byte
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7e, 1'b0);
    push_byte(CHAR_SPACE, 1'b0);
    push_byte(CHAR_DEL, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte("z", 1'b0);
    push_byte(CTRL_MAX, 1'b0);
    push_byte("q", 1'b0);
    push_byte(CHAR_SPACE, 1'b1);
    wait_idle();

    // Full-length charset
    set_charset({$urandom, $urandom}, 4'd8);
    queue_random_text(32);
    wait_idle();

    // Length above the limit is clipped
    set_charset(64'hffff_ffff_ffff_ffff, 4'd15);
    queue_random_text(32);
    wait_idle();

    // Zero charset bytes are still emitted
    set_charset(64'h0, 4'd3);
    queue_random_text(32);
    wait_idle();

    // Empty charset name
    set_charset({$urandom, $urandom}, 4'd0);
    queue_random_text(32);
    wait_idle();

    set_charset({$urandom, $urandom}, 4'($urandom_range(0, 15)));
    queue_random_text(32);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS header_q_word_encoder_unit");
    end else begin
      $display("FAIL header_q_word_encoder_unit");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("FAIL header_q_word_encoder_unit");
    $finish;
  end

endmodule
